FILE: rtl/rau_pkg.sv
// rau_pkg: shared types and constants of the rational arithmetic unit
// controller state, operation codes and the command/status structs
// used by rau_ctrl, rau_datapath and rational_arithmetic_unit
package rau_pkg;

  localparam int unsigned WIDE = 64;  // intermediate numerator/denominator width
  localparam int unsigned MULW = 33;  // signed multiplier operand width
  localparam int unsigned KW   = 7;   // common power-of-two count
  localparam int unsigned CNTW = 6;   // divide bit counter

  typedef enum logic [1:0] {
    ACT_ADD,
    ACT_SUB,
    ACT_MUL,
    ACT_DIV
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_MAG,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MSTEP_T1,
    MSTEP_T2,
    MSTEP_DEN
  } mul_step_e;

  typedef enum logic [1:0] {
    RES_NORM,
    RES_ZERO,
    RES_ERR
  } res_kind_e;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_step_e mul_step;
    logic      sum_en;
    logic      mag_en;
    logic      gcd_step;
    logic      div_init;
    logic      div_step;
    logic      out_load;
    res_kind_e res_kind;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic num_zero;
    logic gcd_done;
    logic div_last;
  } status_t;

endpackage

FILE: rtl/rational_arithmetic_unit.sv
// rational_arithmetic_unit: top level, stream ports around rau_ctrl and rau_datapath
// depends on rau_pkg, rau_ctrl, rau_datapath
//
// Combines two rationals (signed numerator over positive denominator) by add,
// subtract, multiply or divide and returns the exact result reduced by the gcd,
// sign in the numerator, zero as 0/1. A zero divisor or zero denominator gives
// 0/1 with div_zero set. One transaction is worked at a time: an accept step,
// the products T1, T2 and the denominator on the shared 33x33 multiplier, sum
// and magnitudes, the binary gcd steps and the divider setup, then the
// bit-serial divider that reduces numerator and denominator together, and the
// output load; an error goes to the output load from the first multiply step,
// a zero result from the magnitude step. A stalled output holds the last step
// until the output register is free. A new transaction is taken while the
// previous result waits at the output register.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // action, a_num, a_den, b_num, b_den
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,  // res_num, res_den, zero pad
  output logic         m_axis_tuser_o   // div_zero
);

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t status;
  logic [63:0]      res_num;
  logic [62:0]      res_den;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rau_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .action_i   (s_axis_tdata_i[1:0]),
    .a_num_i    (s_axis_tdata_i[33:2]),
    .a_den_i    (s_axis_tdata_i[64:34]),
    .b_num_i    (s_axis_tdata_i[96:65]),
    .b_den_i    (s_axis_tdata_i[127:97]),
    .res_num_o  (res_num),
    .res_den_o  (res_den),
    .div_zero_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {1'b0, res_den, res_num};

endmodule

FILE: rtl/rau_ctrl.sv
// rau_ctrl: sequencer of the rational arithmetic unit
// steps the datapath through multiply, reduce and divide phases
// depends on rau_pkg
module rau_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  rau_pkg::status_t status_i,
  output rau_pkg::cmd_t    cmd_o
);

  rau_pkg::state_e    state_q, state_d;
  rau_pkg::res_kind_e kind_q, kind_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == rau_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      rau_pkg::ST_IDLE: if (in_valid_i) state_d = rau_pkg::ST_MUL0;
      rau_pkg::ST_MUL0: begin
        if (status_i.err) begin
          kind_d  = rau_pkg::RES_ERR;
          state_d = rau_pkg::ST_FIN;
        end else begin
          state_d = rau_pkg::ST_MUL1;
        end
      end
      rau_pkg::ST_MUL1: state_d = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2: state_d = rau_pkg::ST_SUM;
      rau_pkg::ST_SUM:  state_d = rau_pkg::ST_MAG;
      rau_pkg::ST_MAG: begin
        if (status_i.num_zero) begin
          kind_d  = rau_pkg::RES_ZERO;
          state_d = rau_pkg::ST_FIN;
        end else begin
          kind_d  = rau_pkg::RES_NORM;
          state_d = rau_pkg::ST_GCD;
        end
      end
      rau_pkg::ST_GCD: if (status_i.gcd_done) state_d = rau_pkg::ST_DIV;
      rau_pkg::ST_DIV: if (status_i.div_last) state_d = rau_pkg::ST_FIN;
      rau_pkg::ST_FIN: if (out_free) state_d = rau_pkg::ST_IDLE;
      default: state_d = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_step = rau_pkg::MSTEP_T1;
    cmd_o.res_kind = kind_q;
    unique case (state_q)
      rau_pkg::ST_IDLE: cmd_o.load = in_valid_i;
      rau_pkg::ST_MUL0: cmd_o.mul_en = 1'b1;
      rau_pkg::ST_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = rau_pkg::MSTEP_T2;
      end
      rau_pkg::ST_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = rau_pkg::MSTEP_DEN;
      end
      rau_pkg::ST_SUM: cmd_o.sum_en = 1'b1;
      rau_pkg::ST_MAG: cmd_o.mag_en = 1'b1;
      rau_pkg::ST_GCD: begin
        cmd_o.gcd_step = !status_i.gcd_done;
        cmd_o.div_init = status_i.gcd_done;
      end
      rau_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      rau_pkg::ST_FIN: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::ST_IDLE;
      kind_q      <= rau_pkg::RES_NORM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/rau_datapath.sv
// rau_datapath: operand registers, shared multiplier, binary gcd and
// two-lane restoring divider of the rational arithmetic unit
// depends on rau_pkg
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rau_pkg::cmd_t                   cmd_i,
  output rau_pkg::status_t                status_o,
  input  logic [1:0]                      action_i,
  input  logic [31:0]                     a_num_i,
  input  logic [30:0]                     a_den_i,
  input  logic [31:0]                     b_num_i,
  input  logic [30:0]                     b_den_i,
  output logic [rau_pkg::WIDE-1:0]        res_num_o,
  output logic [rau_pkg::WIDE-2:0]        res_den_o,
  output logic                            div_zero_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned MW = rau_pkg::MULW;
  localparam int unsigned XW = rau_pkg::WIDE;

  rau_pkg::action_e        act_q;
  logic signed [MW-1:0]    an_q, ad_q, bn_q, bd_q;
  logic signed [MW-1:0]    mx, my;
  logic signed [2*MW-1:0]  prod;
  logic signed [XW-1:0]    t1_q, t2_q, den_q, num_q;
  logic [XW-1:0]           nm_q, dm_q, u_q, v_q, g_q;
  logic [rau_pkg::KW-1:0]  k_q;
  logic                    neg_q;
  logic [XW-1:0]           qn_q, qd_q, rn_q, rd_q;
  logic [XW:0]             rn_sh, rd_sh;
  logic                    rn_ge, rd_ge;
  logic [rau_pkg::CNTW-1:0] cnt_q;
  logic [XW-1:0]           res_num_q;
  logic [XW-2:0]           res_den_q;
  logic                    dz_q;

  // operand selection for the shared multiplier
  always_comb begin
    mx = an_q;
    my = bd_q;
    unique case (cmd_i.mul_step)
      rau_pkg::MSTEP_T1: begin
        mx = an_q;
        my = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q;
      end
      rau_pkg::MSTEP_T2: begin
        mx = bn_q;
        my = ad_q;
      end
      rau_pkg::MSTEP_DEN: begin
        mx = ad_q;
        my = (act_q == rau_pkg::ACT_DIV) ? bn_q : bd_q;
      end
      default: begin
        mx = an_q;
        my = bd_q;
      end
    endcase
  end

  assign prod = mx * my;

  assign status_o.err = (ad_q == '0) || (bd_q == '0) ||
                        ((act_q == rau_pkg::ACT_DIV) && (bn_q == '0));
  assign status_o.num_zero = (num_q == '0);
  assign status_o.gcd_done = (u_q == '0) || (v_q == '0);
  assign status_o.div_last = (cnt_q == '1);

  // one restoring divide step per lane, both lanes share the divisor
  assign rn_sh = {rn_q, qn_q[XW-1]};
  assign rd_sh = {rd_q, qd_q[XW-1]};
  assign rn_ge = (rn_sh >= {1'b0, g_q});
  assign rd_ge = (rd_sh >= {1'b0, g_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= rau_pkg::ACT_ADD;
      an_q      <= '0;
      ad_q      <= '0;
      bn_q      <= '0;
      bd_q      <= '0;
      t1_q      <= '0;
      t2_q      <= '0;
      den_q     <= '0;
      num_q     <= '0;
      nm_q      <= '0;
      dm_q      <= '0;
      u_q       <= '0;
      v_q       <= '0;
      g_q       <= '0;
      k_q       <= '0;
      neg_q     <= 1'b0;
      qn_q      <= '0;
      qd_q      <= '0;
      rn_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
      res_num_q <= '0;
      res_den_q <= (XW-1)'(1);
      dz_q      <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        act_q <= rau_pkg::action_e'(action_i);
        an_q  <= MW'(signed'(a_num_i[W-1:0]));
        bn_q  <= MW'(signed'(b_num_i[W-1:0]));
        ad_q  <= signed'({{(MW-W+1){1'b0}}, a_den_i[W-2:0]});
        bd_q  <= signed'({{(MW-W+1){1'b0}}, b_den_i[W-2:0]});
      end
      if (cmd_i.mul_en) begin
        unique case (cmd_i.mul_step)
          rau_pkg::MSTEP_T1:  t1_q  <= prod[XW-1:0];
          rau_pkg::MSTEP_T2:  t2_q  <= prod[XW-1:0];
          rau_pkg::MSTEP_DEN: den_q <= prod[XW-1:0];
          default:            t1_q  <= prod[XW-1:0];
        endcase
      end
      if (cmd_i.sum_en) begin
        unique case (act_q)
          rau_pkg::ACT_ADD: num_q <= t1_q + t2_q;
          rau_pkg::ACT_SUB: num_q <= t1_q - t2_q;
          default:          num_q <= t1_q;
        endcase
      end
      if (cmd_i.mag_en) begin
        nm_q  <= num_q[XW-1] ? -num_q : num_q;
        dm_q  <= den_q[XW-1] ? -den_q : den_q;
        u_q   <= num_q[XW-1] ? -num_q : num_q;
        v_q   <= den_q[XW-1] ? -den_q : den_q;
        k_q   <= '0;
        neg_q <= num_q[XW-1] ^ den_q[XW-1];
      end
      if (cmd_i.gcd_step) begin
        priority if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      if (cmd_i.div_init) begin
        g_q   <= (u_q | v_q) << k_q;
        qn_q  <= nm_q;
        qd_q  <= dm_q;
        rn_q  <= '0;
        rd_q  <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        rn_q  <= rn_ge ? XW'(rn_sh - {1'b0, g_q}) : rn_sh[XW-1:0];
        rd_q  <= rd_ge ? XW'(rd_sh - {1'b0, g_q}) : rd_sh[XW-1:0];
        qn_q  <= {qn_q[XW-2:0], rn_ge};
        qd_q  <= {qd_q[XW-2:0], rd_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        unique case (cmd_i.res_kind)
          rau_pkg::RES_NORM: begin
            res_num_q <= neg_q ? -qn_q : qn_q;
            res_den_q <= qd_q[XW-2:0];
            dz_q      <= 1'b0;
          end
          rau_pkg::RES_ZERO: begin
            res_num_q <= '0;
            res_den_q <= (XW-1)'(1);
            dz_q      <= 1'b0;
          end
          default: begin
            res_num_q <= '0;
            res_den_q <= (XW-1)'(1);
            dz_q      <= 1'b1;
          end
        endcase
      end
    end
  end

  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign div_zero_o = dz_q;

endmodule
